[hdl/clms_pkg.sv]
// Package for the character LED matrix scanner: word types, job type,
// result kinds and the constant glyph table. No dependencies.
package clms_pkg;

  localparam int unsigned Glyphs = 36;

  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_SHIFT = 2'd0,
    KIND_LATCH = 2'd1,
    KIND_OFF   = 2'd2
  } kind_e;

  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    kind_e      kind;
    logic       serial_bit;
    logic [7:0] row_pattern;
    logic [7:0] column_select;
    logic       last;
  } out_word_t;

  // one unit of back-end work: a blanking word or a full column refresh
  typedef struct packed {
    logic       blank;
    logic [7:0] row;
    logic [2:0] col;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [7:0] GLYPH_ROM [Glyphs][8] = '{
    '{8'hFF,8'hC1,8'h80,8'hAE,8'hB6,8'h80,8'hC1,8'hFF},
    '{8'hFF,8'hFE,8'hEE,8'h80,8'h80,8'hFE,8'hFE,8'hFF},
    '{8'hFF,8'hDC,8'h98,8'hBA,8'hB6,8'h86,8'hCE,8'hFF},
    '{8'hFF,8'hDD,8'h9C,8'hB6,8'hB6,8'h80,8'hC9,8'hFF},
    '{8'hFF,8'hF3,8'hEB,8'hDB,8'h80,8'h80,8'hFB,8'hFF},
    '{8'hFF,8'h8D,8'h8C,8'hAE,8'hAE,8'hA0,8'hB1,8'hFF},
    '{8'hFF,8'hC1,8'h80,8'hB6,8'hB6,8'h90,8'hD9,8'hFF},
    '{8'hFF,8'h9F,8'h9F,8'hB8,8'hA0,8'h87,8'h9F,8'hFF},
    '{8'hFF,8'hC9,8'h80,8'hB6,8'hB6,8'h80,8'hC9,8'hFF},
    '{8'hFF,8'hCD,8'h84,8'hB6,8'hB6,8'h80,8'hC1,8'hFF},
    '{8'hFF,8'hC0,8'h80,8'hB7,8'hB7,8'h80,8'hC0,8'hFF},
    '{8'hFF,8'h80,8'h80,8'hB6,8'hB6,8'h80,8'hC9,8'hFF},
    '{8'hFF,8'hC1,8'h80,8'hBE,8'hBE,8'h9C,8'hDD,8'hFF},
    '{8'hFF,8'h80,8'h80,8'hBE,8'hBE,8'h80,8'hC1,8'hFF},
    '{8'hFF,8'h80,8'h80,8'hB6,8'hB6,8'hBE,8'hBE,8'hFF},
    '{8'hFF,8'h80,8'h80,8'hB7,8'hB7,8'hBF,8'hBF,8'hFF},
    '{8'hFF,8'hC1,8'h80,8'hBE,8'hBA,8'h98,8'hD9,8'hFF},
    '{8'hFF,8'h80,8'h80,8'hF7,8'hF7,8'h80,8'h80,8'hFF},
    '{8'hFF,8'hFF,8'hBE,8'h80,8'h80,8'hBE,8'hFF,8'hFF},
    '{8'hFF,8'hF9,8'hF8,8'hBE,8'h80,8'h81,8'hBF,8'hFF},
    '{8'hFF,8'h80,8'h80,8'hE3,8'hC9,8'h9C,8'hBE,8'hFF},
    '{8'hFF,8'h80,8'h80,8'hFE,8'hFE,8'hFE,8'hFE,8'hFF},
    '{8'hFF,8'h80,8'h80,8'hCF,8'hE7,8'hCF,8'h80,8'h80},
    '{8'hFF,8'h80,8'h80,8'hCF,8'hE7,8'hF3,8'h80,8'h80},
    '{8'hFF,8'hC1,8'h80,8'hBE,8'hBE,8'h80,8'hC1,8'hFF},
    '{8'hFF,8'h80,8'h80,8'hBB,8'hBB,8'h83,8'hC7,8'hFF},
    '{8'hFF,8'hC3,8'h81,8'hBD,8'hBD,8'h80,8'hC2,8'hFF},
    '{8'hFF,8'h80,8'h80,8'hB3,8'hB1,8'h84,8'hCE,8'hFF},
    '{8'hFF,8'hCD,8'h84,8'hB6,8'hB6,8'h90,8'hD9,8'hFF},
    '{8'hFF,8'h9F,8'hBF,8'h80,8'h80,8'hBF,8'h9F,8'hFF},
    '{8'hFF,8'h81,8'h80,8'hFE,8'hFE,8'h80,8'h80,8'hFF},
    '{8'hFF,8'h83,8'h81,8'hFC,8'hFC,8'h81,8'h83,8'hFF},
    '{8'hFF,8'h80,8'h80,8'hF9,8'hF3,8'hF9,8'h80,8'h80},
    '{8'hFF,8'h9C,8'h88,8'hE3,8'hF7,8'hE3,8'h88,8'h9C},
    '{8'hFF,8'h8F,8'h87,8'hF0,8'hF0,8'h87,8'h8F,8'hFF},
    '{8'hFF,8'hBC,8'hB8,8'hB2,8'hA6,8'h8E,8'h9E,8'hFF}
  };

endpackage

[hdl/clms_front.sv]
// Front end: accepts words, decodes characters, runs the column/dwell
// bookkeeping and pushes column or blank jobs. Uses clms_pkg.
module clms_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  clms_pkg::in_word_t in_word_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  clms_pkg::q_status_t q_status_i,
  output logic              push_o,
  output clms_pkg::job_t    job_o
);
  import clms_pkg::*;

  logic [7:0] dwell_ticks_q;
  logic [5:0] shown_glyph_q, shown_glyph_d;
  logic       showing_q, showing_d;
  logic       pend_q, pend_d;
  logic [5:0] pend_glyph_q, pend_glyph_d;
  logic       pend_blank_q, pend_blank_d;
  logic [2:0] col_q, col_d;
  logic [7:0] dwell_q, dwell_d;

  logic       accept;
  logic       take;
  logic       lit;
  logic [5:0] glyph;
  logic [7:0] dwell_eff;
  logic [7:0] dwell_next;
  logic [5:0] dec_glyph;
  logic       dec_blank;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign dwell_eff  = (dwell_ticks_q == 8'd0) ? 8'd1 : dwell_ticks_q;

  always_comb begin
    dec_blank = 1'b0;
    dec_glyph = 6'd0;
    case (in_word_i.char_code) inside
      [8'd48:8'd57]:  dec_glyph = 6'(in_word_i.char_code - 8'd48);
      [8'd65:8'd90]:  dec_glyph = 6'(in_word_i.char_code - 8'd55);
      [8'd97:8'd122]: dec_glyph = 6'(in_word_i.char_code - 8'd87);
      default:        dec_blank = 1'b1;
    endcase
  end

  // frame boundary: first column, not yet started
  assign take  = (dwell_q == 8'd0) && (col_q == 3'd0) && pend_q;
  assign lit   = take ? !pend_blank_q : showing_q;
  assign glyph = take ? pend_glyph_q : shown_glyph_q;

  always_comb begin
    shown_glyph_d = shown_glyph_q;
    showing_d     = showing_q;
    pend_d        = pend_q;
    pend_glyph_d  = pend_glyph_q;
    pend_blank_d  = pend_blank_q;
    col_d         = col_q;
    dwell_d       = dwell_q;
    dwell_next    = dwell_q;
    push_o        = 1'b0;
    job_o.blank   = 1'b0;
    job_o.row     = GLYPH_ROM[glyph][col_q];
    job_o.col     = col_q;
    if (accept) begin
      if (in_word_i.func == FUNC_CHAR) begin
        if (!pend_q) begin
          pend_d       = 1'b1;
          pend_glyph_d = dec_glyph;
          pend_blank_d = dec_blank;
        end
      end else begin
        if (take) begin
          pend_d = 1'b0;
          if (pend_blank_q) begin
            showing_d   = 1'b0;
            push_o      = 1'b1;
            job_o.blank = 1'b1;
          end else begin
            showing_d     = 1'b1;
            shown_glyph_d = pend_glyph_q;
          end
        end
        if (lit) begin
          if (dwell_q == 8'd0) begin
            push_o     = 1'b1;
            dwell_next = dwell_eff - 8'd1;
          end else begin
            dwell_next = dwell_q - 8'd1;
          end
          dwell_d = dwell_next;
          if (dwell_next == 8'd0) begin
            col_d = col_q + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ticks_q <= 8'd1;
      shown_glyph_q <= 6'd0;
      showing_q     <= 1'b0;
      pend_q        <= 1'b0;
      pend_glyph_q  <= 6'd0;
      pend_blank_q  <= 1'b0;
      col_q         <= 3'd0;
      dwell_q       <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        dwell_ticks_q <= cfg_wdata_i;
      end
      shown_glyph_q <= shown_glyph_d;
      showing_q     <= showing_d;
      pend_q        <= pend_d;
      pend_glyph_q  <= pend_glyph_d;
      pend_blank_q  <= pend_blank_d;
      col_q         <= col_d;
      dwell_q       <= dwell_d;
    end
  end

endmodule

[hdl/clms_fifo.sv]
// Two-entry job queue between front and back end. Uses clms_pkg.
module clms_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  clms_pkg::job_t      job_i,
  input  logic                pop_i,
  output clms_pkg::job_t      job_o,
  output clms_pkg::q_status_t status_o
);
  import clms_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign job_o          = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[hdl/clms_back.sv]
// Back end: expands a job into output words (eight shift bits and a
// latch, or one blanking word). Uses clms_pkg.
module clms_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clms_pkg::job_t      job_i,
  input  clms_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output clms_pkg::out_word_t out_word_o
);
  import clms_pkg::*;

  logic       busy_q;
  logic       blank_q;
  logic [7:0] row_q;
  logic [7:0] shift_q;
  logic [2:0] col_q;
  logic [3:0] cnt_q;
  logic       is_latch;
  logic       is_last;
  logic       fire;

  assign is_latch = (cnt_q == 4'd8);
  assign is_last  = blank_q || is_latch;
  assign fire     = busy_q && !out_stall_i;
  assign pop_o    = !q_status_i.empty && (!busy_q || (fire && is_last));

  assign out_valid_o = busy_q;

  always_comb begin
    out_word_o.kind          = KIND_SHIFT;
    out_word_o.serial_bit    = 1'b0;
    out_word_o.row_pattern   = 8'h00;
    out_word_o.column_select = 8'h00;
    out_word_o.last          = is_last;
    if (blank_q) begin
      out_word_o.kind = KIND_OFF;
    end else if (is_latch) begin
      out_word_o.kind          = KIND_LATCH;
      out_word_o.row_pattern   = row_q;
      out_word_o.column_select = 8'h01 << col_q;
    end else begin
      out_word_o.serial_bit = shift_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      row_q   <= job_i.row;
      shift_q <= job_i.row;
      col_q   <= job_i.col;
    end else if (fire) begin
      shift_q <= {shift_q[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      blank_q <= 1'b0;
      cnt_q   <= 4'd0;
    end else begin
      if (pop_o) begin
        busy_q  <= 1'b1;
        blank_q <= job_i.blank;
        cnt_q   <= 4'd0;
      end else if (fire) begin
        if (is_last) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

endmodule

[hdl/char_led_matrix_scanner.sv]
// 8x8 LED matrix character scanner, column multiplexed. A character word
// selects a glyph ('0'-'9', 'A'-'Z', case folded; anything else blanks)
// that takes effect at the next frame boundary; a tick word that starts a
// column produces nine output words (eight row bits MSB first, then a
// latch with one-hot column select), and a blank request produces one
// all-off word. The front end takes one input word per cycle while the
// two-entry job queue has room; the back end sends one output word per
// cycle while the receiver does not stall, so a column refresh occupies it for nine words and a blank for one.
// Top level; depends on clms_pkg, clms_front, clms_fifo, clms_back.
module char_led_matrix_scanner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  clms_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output clms_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);
  import clms_pkg::*;

  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head_job;
  q_status_t q_status;

  clms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  clms_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .status_o(q_status)
  );

  clms_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (head_job),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

[hdl/clms_checker.sv]
// Port-level checks for the scanner and the bind that attaches them.
// Depends on clms_pkg and char_led_matrix_scanner.
module clms_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input clms_pkg::out_word_t out_word_o
);
  import clms_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_latch_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == KIND_LATCH) |->
      $onehot(out_word_o.column_select) && out_word_o.last && !out_word_o.serial_bit)
    else $error("bad latch word");

  a_shift_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == KIND_SHIFT) |->
      !out_word_o.last && (out_word_o.row_pattern == 8'h00)
      && (out_word_o.column_select == 8'h00))
    else $error("bad shift word");

  a_off_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == KIND_OFF) |->
      out_word_o.last && !out_word_o.serial_bit && (out_word_o.row_pattern == 8'h00)
      && (out_word_o.column_select == 8'h00))
    else $error("bad blanking word");

  a_shift_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (out_word_o.kind == KIND_SHIFT) |=> out_valid_o)
    else $error("column sequence broken");

endmodule

bind char_led_matrix_scanner clms_checker u_clms_checker (.*);

[verif/scan_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the character LED matrix scanner: watches the input, output
// and register ports, predicts every output word and compares it. Uses clms_pkg.
module scan_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  clms_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  clms_pkg::out_word_t out_word_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  words_o
);
  import clms_pkg::*;

  // shadow of the scanner state
  logic [7:0] dwell_reg;
  logic [5:0] shown_glyph;
  logic       lit;
  logic       req_valid;
  logic [5:0] req_glyph;
  logic       req_blank;
  logic [2:0] col_idx;
  logic [7:0] dwell_left;
  out_word_t  scan_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    // keep the log short on a broken design, but count everything
    if (fail_cnt_o < 25) begin
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
    fail_cnt_o++;
  endtask

  task automatic push_word(input kind_e k, input logic sbit, input logic [7:0] row,
                           input logic [7:0] col, input logic last);
    out_word_t w;
    w.kind          = k;
    w.serial_bit    = sbit;
    w.row_pattern   = row;
    w.column_select = col;
    w.last          = last;
    scan_q.push_back(w);
  endtask

  // one accepted input word -> expected output words
  task automatic scan_word(input in_word_t w);
    logic [7:0] code;
    logic [7:0] row;
    code = w.char_code;
    if (w.func == FUNC_CHAR) begin
      // a second request while one waits for the frame boundary is dropped
      if (!req_valid) begin
        req_valid = 1'b1;
        req_blank = 1'b0;
        if (code >= 8'd48 && code <= 8'd57) begin
          req_glyph = 6'(code - 8'd48);
        end else if (code >= 8'd65 && code <= 8'd90) begin
          req_glyph = 6'(code - 8'd55);
        end else if (code >= 8'd97 && code <= 8'd122) begin
          req_glyph = 6'(code - 8'd87);
        end else begin
          req_glyph = '0;
          req_blank = 1'b1;
        end
      end
      return;
    end

    if (dwell_left == 0 && col_idx == 0 && req_valid) begin
      req_valid = 1'b0;
      if (req_blank) begin
        lit = 1'b0;
        push_word(KIND_OFF, 1'b0, 8'h00, 8'h00, 1'b1);
        return;
      end
      lit         = 1'b1;
      shown_glyph = req_glyph;
    end
    if (!lit) return;

    if (dwell_left == 0) begin
      row = GLYPH_ROM[shown_glyph][col_idx];
      for (int b = 7; b >= 0; b--) begin
        push_word(KIND_SHIFT, row[b], 8'h00, 8'h00, 1'b0);
      end
      push_word(KIND_LATCH, 1'b0, row, 8'h01 << col_idx, 1'b1);
      dwell_left = (dwell_reg == 0) ? 8'd1 : dwell_reg;
    end
    dwell_left--;
    if (dwell_left == 0) col_idx++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      dwell_reg   = 8'd1;
      shown_glyph = '0;
      lit         = 1'b0;
      req_valid   = 1'b0;
      req_glyph   = '0;
      req_blank   = 1'b0;
      col_idx     = '0;
      dwell_left  = '0;
      scan_q.delete();
      fail_cnt_o  = 0;
      pending_o   = 0;
      words_o     = 0;
    end else begin
      if (cfg_we_i) dwell_reg = cfg_wdata_i;
      // input first, so a same-edge output still finds its expectation
      if (in_valid_i && !in_stall_i) scan_word(in_word_i);
      if (out_valid_i && !out_stall_i) begin
        words_o++;
        if (scan_q.size() == 0) begin
          report("unexpected word", 32'(out_word_i), 32'h0);
        end else begin
          want = scan_q.pop_front();
          if (out_word_i.kind !== want.kind)
            report("kind", 32'(out_word_i.kind), 32'(want.kind));
          if (out_word_i.serial_bit !== want.serial_bit)
            report("serial_bit", 32'(out_word_i.serial_bit), 32'(want.serial_bit));
          if (out_word_i.row_pattern !== want.row_pattern)
            report("row_pattern", 32'(out_word_i.row_pattern), 32'(want.row_pattern));
          if (out_word_i.column_select !== want.column_select)
            report("column_select", 32'(out_word_i.column_select),
                   32'(want.column_select));
          if (out_word_i.last !== want.last)
            report("last", 32'(out_word_i.last), 32'(want.last));
        end
      end
      pending_o = scan_q.size();
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Top of the character LED matrix scanner testbench: clock, reset, stimulus
// and verdict. Depends on clms_pkg, char_led_matrix_scanner and scan_checker.
module tb_top;
  import clms_pkg::*;

  // drain time after the last expected word: two queued column jobs and margin
  localparam int Settle = 32;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_word;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         fail_cnt;
  int         pending;
  int         words;

  int n_sent = 0;
  int n_cfg = 0;
  int burst_left = 8;

  always #5 clk = ~clk;

  char_led_matrix_scanner u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  scan_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .words_o     (words)
  );

  function automatic in_word_t tick(input logic [7:0] code);
    in_word_t w;
    w.func      = FUNC_TICK;
    w.char_code = code;
    return w;
  endfunction

  function automatic in_word_t chr(input logic [7:0] code);
    in_word_t w;
    w.func      = FUNC_CHAR;
    w.char_code = code;
    return w;
  endfunction

  // mostly glyph characters; the rest random bytes, which mostly blank
  function automatic in_word_t rand_word(input int tick_pct);
    in_word_t w;
    int pick;
    w.char_code = 8'($urandom_range(0, 255));
    w.func      = ($urandom_range(0, 99) < tick_pct) ? FUNC_TICK : FUNC_CHAR;
    if (w.func == FUNC_CHAR) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) w.char_code = 8'($urandom_range(48, 57));
      else if (pick < 6) w.char_code = 8'($urandom_range(65, 90));
      else if (pick < 8) w.char_code = 8'($urandom_range(97, 122));
    end
    return w;
  endfunction

  // sender bursts and gaps
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // called right after a rising edge; returns at the edge that took the word, or after the sender gap that follows it
  task automatic put_word(input in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    pace();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] dwell, input int n_words, input int tick_pct);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= dwell;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
    repeat (n_words) put_word(rand_word(tick_pct));
  endtask

  // receiver stall pattern, changing mode now and then
  initial begin
    int mode;
    int len;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(8, 64);
      for (int k = 0; k < len; k++) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ((k % 7) < 4);
          default: out_stall <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, dwell still at its reset value of one
    put_word(tick(8'h00));   // blank, nothing pending: silent
    put_word(chr(8'd48));    // '0'
    put_word(chr(8'd122));   // dropped, '0' still pending
    put_word(tick(8'hFF));   // frame boundary takes '0', column 0
    repeat (7) put_word(tick(8'($urandom_range(0, 255))));
    put_word(chr(8'h00));    // blank request
    put_word(tick(8'h5A));   // all-off word
    put_word(tick(8'hA5));   // blank and idle again
    put_word(chr(8'd90));    // 'Z'
    put_word(tick(8'h00));
    put_word(chr(8'd97));    // 'a' waits for the frame to end
    put_word(chr(8'hFF));    // dropped
    repeat (7) put_word(tick(8'($urandom_range(0, 255))));
    put_word(tick(8'h00));   // 'a' shows from column 0

    run_phase(8'd0, 40, 70);     // zero acts as one
    run_phase(8'd3, 60, 75);
    run_phase(8'd255, 150, 97);
    run_phase(8'd1, 60, 65);
    run_phase(8'd2, 50, 70);
    run_phase(8'($urandom_range(1, 6)), 50, 70);

    settle();
    $display("Run summary: %0d input words over %0d register settings, %0d output words checked",
             n_sent, n_cfg, words);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout: scanner stopped making progress");
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
hdl/clms_pkg.sv
hdl/clms_front.sv
hdl/clms_fifo.sv
hdl/clms_back.sv
hdl/char_led_matrix_scanner.sv
hdl/clms_checker.sv
verif/scan_checker.sv
verif/tb_top.sv
